/* hdl/toe_pkg.sv */
// Shared types, constants and helpers for the TCP option order extractor.
`timescale 1ns / 1ps

package toe_pkg;

    // Letter capacity per options area; the 4-bit count limits it to 15.
    localparam int ORDER_CAPACITY = 15;
    localparam logic [3:0] LETTER_CAP =
        (ORDER_CAPACITY < 15) ? 4'(ORDER_CAPACITY) : 4'd15;

    // Queue between parser and emitter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // TCP option kinds
    localparam logic [7:0] KIND_EOL  = 8'd0;
    localparam logic [7:0] KIND_NOP  = 8'd1;
    localparam logic [7:0] KIND_MSS  = 8'd2;
    localparam logic [7:0] KIND_WS   = 8'd3;
    localparam logic [7:0] KIND_SACK = 8'd4;
    localparam logic [7:0] KIND_TS   = 8'd8;
    localparam logic [7:0] MIN_LEN   = 8'd2;

    // ASCII letters
    localparam logic [6:0] CH_M    = 7'h4D;
    localparam logic [6:0] CH_W    = 7'h57;
    localparam logic [6:0] CH_S    = 7'h53;
    localparam logic [6:0] CH_T    = 7'h54;
    localparam logic [6:0] CH_N    = 7'h4E;
    localparam logic [6:0] CH_E    = 7'h45;
    localparam logic [6:0] CH_NONE = 7'h00;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_KIND = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    // One queued work entry: an optional letter and an optional closing count.
    typedef struct packed {
        logic       letter_vld;
        logic [6:0] letter;
        logic       done;
        logic [3:0] count;
    } t_entry;

    function automatic logic [6:0] kind_letter(input logic [7:0] kind);
        logic [6:0] l;
        unique case (kind)
            KIND_MSS:  l = CH_M;
            KIND_WS:   l = CH_W;
            KIND_SACK: l = CH_S;
            KIND_TS:   l = CH_T;
            default:   l = CH_NONE;
        endcase
        return l;
    endfunction

endpackage

/* hdl/tcp_option_order_extract_top.sv */
// Top level of the TCP option order extractor.
// Path: an accepted byte's entry is written into the queue, then loaded into the emitter output
//   register once it is at the queue head and that register is free; a letter plus count gives two results.
// Throughput: one option byte per cycle; input stalls only when the 4-entry queue fills,
//   under m_axis_tready backpressure or runs of final bytes giving a letter and the count.
// Reset: i_rst_n synchronous, active low; parser returns to the kind phase, queue and
//   output register empty. The parser also clears itself after each final byte.
`timescale 1ns / 1ps

module tcp_option_order_extract_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] option_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] letter, [10:7] letter_count, rest zero
    output logic        m_axis_tuser,   // letter_valid
    output logic        m_axis_tlast    // done_res
);
    import toe_pkg::*;

    t_entry     push_entry, head_entry;
    logic       push, pop, q_full, q_empty, accept;
    logic [6:0] letter;
    logic [3:0] count;

    // Input is taken whenever the queue has room; the parser never waits.
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    toe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_final  (s_axis_tlast),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    toe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    // Emitter splits an entry carrying both a letter and the count into two items.
    toe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head_entry),
        .o_pop          (pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_letter       (letter),
        .o_letter_valid (m_axis_tuser),
        .o_count        (count),
        .o_done         (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, count, letter};

endmodule

/* hdl/toe_front.sv */
// Option parser: walks kind/length bytes and queues letter and count work.
`timescale 1ns / 1ps

module toe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_final,
    output logic            o_push,
    output toe_pkg::t_entry o_entry
);
    import toe_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_skip, n_skip;
    logic [6:0] r_pend, n_pend;
    logic [3:0] r_cnt, n_cnt;
    logic       r_stop, n_stop;

    logic       emit;
    logic [6:0] emit_letter;
    logic [7:0] skip_dec;

    assign skip_dec = r_skip - 8'd1;

    always_comb begin
        n_phase     = r_phase;
        n_skip      = r_skip;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_stop      = r_stop;
        emit        = 1'b0;
        emit_letter = CH_NONE;
        if (r_stop || (r_cnt >= LETTER_CAP)) begin
            n_stop = 1'b1;
        end else begin
            unique case (r_phase)
                PH_KIND: begin
                    if (i_byte == KIND_EOL) begin
                        emit        = 1'b1;
                        emit_letter = CH_E;
                        n_stop      = 1'b1;
                    end else if (i_byte == KIND_NOP) begin
                        emit        = 1'b1;
                        emit_letter = CH_N;
                    end else begin
                        n_pend  = kind_letter(i_byte);
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (i_byte < MIN_LEN) begin
                        n_stop = 1'b1;
                    end else begin
                        n_skip = i_byte - MIN_LEN;
                        if (i_byte == MIN_LEN) begin
                            emit        = (r_pend != CH_NONE);
                            emit_letter = r_pend;
                            n_phase     = PH_KIND;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    n_skip = skip_dec;
                    if (skip_dec == 8'd0) begin
                        emit        = (r_pend != CH_NONE);
                        emit_letter = r_pend;
                        n_phase     = PH_KIND;
                    end
                end
                default: n_phase = PH_KIND;
            endcase
        end
        if (emit) begin
            n_cnt = r_cnt + 4'd1;
            if (n_cnt >= LETTER_CAP) begin
                n_stop = 1'b1;
            end
        end
    end

    assign o_push             = i_accept && (emit || i_final);
    assign o_entry.letter_vld = emit;
    assign o_entry.letter     = emit_letter;
    assign o_entry.done       = i_final;
    assign o_entry.count      = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_KIND;
            r_skip  <= '0;
            r_pend  <= CH_NONE;
            r_cnt   <= '0;
            r_stop  <= 1'b0;
        end else if (i_accept) begin
            if (i_final) begin
                r_phase <= PH_KIND;
                r_skip  <= '0;
                r_pend  <= CH_NONE;
                r_cnt   <= '0;
                r_stop  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_skip  <= n_skip;
                r_pend  <= n_pend;
                r_cnt   <= n_cnt;
                r_stop  <= n_stop;
            end
        end
    end

endmodule

/* hdl/toe_queue.sv */
// Short register queue of parser work entries.
`timescale 1ns / 1ps

module toe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  toe_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output toe_pkg::t_entry o_head
);
    import toe_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue fill count out of step");

endmodule

/* hdl/toe_back.sv */
// Result emitter: turns queued entries into letter and count results.
`timescale 1ns / 1ps

module toe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  toe_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [6:0]      o_letter,
    output logic            o_letter_valid,
    output logic [3:0]      o_count,
    output logic            o_done
);
    import toe_pkg::*;

    logic       r_sub;      // letter of head entry already sent
    logic       r_valid;
    logic [6:0] r_letter;
    logic       r_lv;
    logic [3:0] r_count;
    logic       r_done;

    logic load, send_letter;

    assign load        = !i_empty && (!r_valid || i_ready);
    assign send_letter = i_head.letter_vld && !r_sub;
    assign o_pop       = load && !(send_letter && i_head.done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= send_letter && i_head.done;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (send_letter) begin
                r_letter <= i_head.letter;
                r_lv     <= 1'b1;
                r_count  <= '0;
                r_done   <= 1'b0;
            end else begin
                r_letter <= CH_NONE;
                r_lv     <= 1'b0;
                r_count  <= i_head.count;
                r_done   <= 1'b1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_letter       = r_letter;
    assign o_letter_valid = r_lv;
    assign o_count        = r_count;
    assign o_done         = r_done;

    a_sub_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (!i_empty && i_head.done && i_head.letter_vld))
        else $error("split entry lost from queue head");

    a_sub_after_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sub) |-> (r_valid && r_lv))
        else $error("split entry without its letter result");

    a_letter_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_lv != r_done))
        else $error("result is neither letter nor count");

endmodule
